// ===== hw/rtl/bmpq_pkg.sv =====
// Package for the bounded minimum-priority queue.
// Holds sizes, operation and status codes, the controller state type and
// the command word shared by the controller and the datapath.
package bmpq_pkg;

  // Storage size and derived widths.
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam int STAT_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Operation codes carried in the kind field.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic exec;
  } cmd_t;

endpackage

// ===== hw/rtl/bmpq_ctrl.sv =====
// Controller of the bounded minimum-priority queue.
// Sequences capture, execution and output handoff; depends on bmpq_pkg.
module bmpq_ctrl import bmpq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands. A captured word executes only once the
  // output register is free or being emptied in the same cycle.
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid || out_ready) begin
          cmd.exec       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/bmpq_datapath.sv =====
// Datapath of the bounded minimum-priority queue: the sorted register
// chain, the count, the capacity register and the result register.
// Depends on bmpq_pkg.
module bmpq_datapath import bmpq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  input  logic                     kind,
  input  logic signed [VAL_W-1:0]  value,
  input  logic                     cfg_valid,
  input  logic [CAP_W-1:0]         cfg_data,
  output logic signed [VAL_W-1:0]  removed_value,
  output logic [STAT_W-1:0]        status,
  output logic [CNT_W-1:0]         occupancy
);

  logic                    kind_q;
  logic signed [VAL_W-1:0] value_q;
  logic signed [VAL_W-1:0] cells [DEPTH];
  logic signed [VAL_W-1:0] cells_next [DEPTH];
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [CAP_W-1:0]        capacity;
  logic [CNT_W-1:0]        limit;
  logic [DEPTH-1:0]        le;
  logic signed [VAL_W-1:0] removed_next;
  logic [STAT_W-1:0]       status_next;

  // Capacity register and clamp to the chain length.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  always_comb begin
    if (int'(capacity) > DEPTH) begin
      limit = CNT_W'(DEPTH);
    end else begin
      limit = CNT_W'(capacity);
    end
  end

  // Every occupied cell compares itself with the new value at once. Since
  // the chain is sorted, the set flags form a prefix of the chain.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le[i] = (CNT_W'(i) < count) && (cells[i] <= value_q);
    end
  end

  // Next chain contents, count and result for the captured word.
  always_comb begin
    count_next   = count;
    removed_next = '0;
    status_next  = ST_OK;
    for (int i = 0; i < DEPTH; i++) begin
      cells_next[i] = cells[i];
    end
    if (kind_q == KIND_INSERT) begin
      if (count >= limit) begin
        status_next = ST_FULL;
      end else begin
        // Cells at or below the new value hold, the first other cell takes
        // the value, and the rest move up by one place.
        if (le[0]) begin
          cells_next[0] = cells[0];
        end else begin
          cells_next[0] = value_q;
        end
        for (int i = 1; i < DEPTH; i++) begin
          if (le[i]) begin
            cells_next[i] = cells[i];
          end else if (le[i-1]) begin
            cells_next[i] = value_q;
          end else begin
            cells_next[i] = cells[i-1];
          end
        end
        count_next = count + 1'b1;
      end
    end else begin
      if (count == '0) begin
        status_next = ST_EMPTY;
      end else begin
        // The head leaves and every cell below the top takes the contents of the one above it.
        removed_next = cells[0];
        for (int i = 0; i < DEPTH - 1; i++) begin
          cells_next[i] = cells[i+1];
        end
        count_next = count - 1'b1;
      end
    end
  end

  // Input capture register.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_q  <= kind;
      value_q <= value;
    end
  end

  // Chain cells; their contents above the count are never read.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        cells[i] <= cells_next[i];
      end
    end
  end

  // Count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      removed_value <= removed_next;
      status        <= status_next;
      occupancy     <= count_next;
    end
  end

endmodule

// ===== hw/rtl/bounded_min_priority_queue.sv =====
// Bounded minimum-priority queue of signed 32-bit values.
// Top level joining bmpq_ctrl and bmpq_datapath; depends on bmpq_pkg.
//
// Usage:
//   Input channel (in_valid, in_ready, kind, value): kind 0 inserts value,
//   kind 1 removes the smallest stored value. Equal values leave in the
//   order they arrived.
//   Output channel (out_valid, out_ready, removed_value, status,
//   occupancy): one result word per input word. status is 0 for ok, 1 for
//   an insert refused because the queue is full, 2 for a removal from an
//   empty queue. occupancy is the count after the operation.
//   Configuration channel (cfg_valid, cfg_ready, cfg_data): writes the
//   capacity; values above 16 act as 16. Write only while idle.
// Timing:
//   A word is captured at the accepting edge and executed once the result
//   register is free, so the result is registered behind the input capture
//   register, and no new word is taken until the last one has executed. The
//   sorted register chain does its compare and shift in parallel.
//   When the receiver stalls, one more word is captured and then held
//   until the result register frees up.
// Reset: synchronous; the queue becomes empty and capacity returns to 16.
module bounded_min_priority_queue import bmpq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    kind,
  input  logic signed [VAL_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] removed_value,
  output logic [STAT_W-1:0]       status,
  output logic [CNT_W-1:0]        occupancy,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CAP_W-1:0]        cfg_data
);

  cmd_t cmd;

  // The capacity register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  bmpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bmpq_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .kind          (kind),
    .value         (value),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .removed_value (removed_value),
    .status        (status),
    .occupancy     (occupancy)
  );

`ifndef SYNTHESIS
  // Occupancy never exceeds the chain length.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occupancy <= CNT_W'(DEPTH))
    else $error("occupancy above chain length");

  // A refused insert or an empty removal reports a zero value.
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL || status == ST_EMPTY) |-> removed_value == '0)
    else $error("nonzero value with error status");

  // An empty removal leaves the queue empty.
  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> occupancy == '0)
    else $error("empty status with nonzero occupancy");

  // A captured word blocks the input until it has executed.
  a_capture: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is pending");
`endif

endmodule

// ===== tb/bmpq_checker.sv =====
`timescale 1ns / 100ps
// Checker for the bounded minimum-priority queue: keeps its own sorted copy of
// the queue, predicts one result word per accepted input word and compares.
// Depends on bmpq_pkg for widths and codes.
module bmpq_checker import bmpq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    kind,
  input  logic signed [VAL_W-1:0] value,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [VAL_W-1:0] removed_value,
  input  logic [STAT_W-1:0]       status,
  input  logic [CNT_W-1:0]        occupancy,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CAP_W-1:0]        cfg_data,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic signed [VAL_W-1:0] removed_value;
    logic [STAT_W-1:0]       status;
    logic [CNT_W-1:0]        occupancy;
  } queue_result_t;

  // Shadow copy of the queue contents, ascending, and of the capacity.
  logic signed [VAL_W-1:0] model_entries [DEPTH];
  int                      model_count;
  logic [CAP_W-1:0]        model_capacity;

  // Result words still owed by the block, oldest first.
  queue_result_t awaited_results [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < 100) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    fail_count++;
  endtask

  // Applies one insert or removal to the shadow queue and returns the answer.
  function automatic queue_result_t apply_queue_op(input logic op,
                                                   input logic signed [VAL_W-1:0] v);
    queue_result_t r;
    int lim;
    int pos;
    lim = (model_capacity > DEPTH) ? DEPTH : int'(model_capacity);
    r.removed_value = '0;
    r.status = ST_OK;
    if (op == KIND_INSERT) begin
      if (model_count >= lim) begin
        r.status = ST_FULL;
      end else begin
        // A new value goes behind every stored value that is not greater.
        pos = 0;
        while (pos < model_count && model_entries[pos] <= v) pos++;
        for (int i = model_count; i > pos; i--) model_entries[i] = model_entries[i-1];
        model_entries[pos] = v;
        model_count++;
      end
    end else if (model_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.removed_value = model_entries[0];
      for (int i = 1; i < model_count; i++) model_entries[i-1] = model_entries[i];
      model_count--;
    end
    r.occupancy = CNT_W'(model_count);
    return r;
  endfunction

  // Watch all three channels at each edge.
  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (rst) begin
      model_count = 0;
      model_capacity = CAP_RESET;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) model_capacity = cfg_data;

      if (out_valid && out_ready) begin
        got.removed_value = removed_value;
        got.status = status;
        got.occupancy = occupancy;
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result word value %0d status %0d occ %0d",
                                    got.removed_value, got.status, got.occupancy));
        end else begin
          want = awaited_results.pop_front();
          if (got.removed_value !== want.removed_value)
            report_mismatch($sformatf("removed_value got %0d want %0d",
                                      got.removed_value, want.removed_value));
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
          if (got.occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy got %0d want %0d",
                                      got.occupancy, want.occupancy));
        end
      end

      if (in_valid && in_ready) awaited_results.push_back(apply_queue_op(kind, value));
    end
    pending <= awaited_results.size();
  end

endmodule

// ===== tb/bounded_min_priority_queue_tb.sv =====
`timescale 1ns / 100ps
// Top of the queue testbench: clock, reset, input and configuration words,
// random receiver stalls and the verdict. Depends on bmpq_pkg, the block and
// bmpq_checker.
module bounded_min_priority_queue_tb;
  import bmpq_pkg::*;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    kind = KIND_INSERT;
  logic signed [VAL_W-1:0] value = '0;
  logic                    out_ready = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [CAP_W-1:0]        cfg_data = '0;
  wire                     in_ready;
  wire                     out_valid;
  wire signed [VAL_W-1:0]  removed_value;
  wire [STAT_W-1:0]        status;
  wire [CNT_W-1:0]         occupancy;
  wire                     cfg_ready;
  int                      fail_count;
  int                      pending;

  // Idling switches, changed per phase.
  bit src_gap_on = 1'b1;
  bit sink_stall_on = 1'b1;

  bounded_min_priority_queue uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .value         (value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .removed_value (removed_value),
    .status        (status),
    .occupancy     (occupancy),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  bmpq_checker chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .value         (value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .removed_value (removed_value),
    .status        (status),
    .occupancy     (occupancy),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Values cluster on extremes and on a narrow band that makes ties likely.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int band;
    band = $urandom_range(0, 16);
    case ($urandom_range(0, 9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2, 3, 4: return band - 8;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stalls, or always ready when stalls are switched off.
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      n = pick_gap(sink_stall_on);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Sends one word; valid stays high after acceptance for a back-to-back word.
  task automatic drive_word(input logic k, input logic signed [VAL_W-1:0] v);
    int n;
    n = pick_gap(src_gap_on);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Holds the sender until every result word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Capacity writes happen only with the block idle.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [CAP_W-1:0] phase_caps [8];
    int ins_pct;
    int n_items;
    logic k;
    phase_caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd9, 5'd16, 5'd3};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: removal from an empty queue, extremes, ties and ordering.
    drive_word(KIND_REMOVE, '0);
    drive_word(KIND_REMOVE, 32'sh7FFFFFFF);
    drive_word(KIND_INSERT, 32'sh7FFFFFFF);
    drive_word(KIND_INSERT, 32'sh80000000);
    drive_word(KIND_INSERT, 32'sh0);
    drive_word(KIND_INSERT, -32'sd1);
    drive_word(KIND_INSERT, 32'sd5);
    drive_word(KIND_INSERT, 32'sd5);
    drive_word(KIND_INSERT, 32'sd1);
    repeat (5) drive_word(KIND_REMOVE, '0);

    // Zero capacity refuses every insert; stored words can still leave.
    write_capacity(5'd0);
    drive_word(KIND_INSERT, 32'sd7);
    drive_word(KIND_REMOVE, '0);

    // Capacity above the storage depth acts as the depth.
    write_capacity(5'd31);
    drive_word(KIND_INSERT, -32'sd2);
    drive_word(KIND_INSERT, 32'sh80000000);

    // Capacity lowered below the current count.
    write_capacity(5'd2);
    drive_word(KIND_INSERT, 32'sd4);
    drive_word(KIND_REMOVE, '0);
    drive_word(KIND_REMOVE, '0);
    drive_word(KIND_INSERT, 32'sd3);
    drive_word(KIND_INSERT, 32'sd8);

    // Random phases over several capacities, mixes and idling patterns.
    for (int p = 0; p < 8; p++) begin
      write_capacity(phase_caps[p]);
      src_gap_on = (p % 3 != 1);
      sink_stall_on = (p % 4 != 2);
      ins_pct = (p % 3 == 0) ? 75 : ((p % 3 == 1) ? 50 : 30);
      if (p == 6) ins_pct = 90;
      n_items = (phase_caps[p] == 0) ? 40 : 115;
      for (int i = 0; i < n_items; i++) begin
        if ((p == 4 && i == 30) || $urandom_range(0, 199) == 0) drain_results();
        k = ($urandom_range(0, 99) < ins_pct) ? KIND_INSERT : KIND_REMOVE;
        drive_word(k, pick_value());
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
